@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the bitmap stream decoder.
// Both macros expect clk_i and rst_ni to exist in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/core/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Types and constants of the bitmap stream to RGB565 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned DIM_OUT_W   = 13;
  localparam int unsigned DIM_SAT     = (2 ** DIM_OUT_W) - 1;

  localparam int unsigned OFS_OFFSET  = 10;
  localparam int unsigned OFS_WIDTH   = 18;
  localparam int unsigned OFS_HEIGHT  = 22;
  localparam int unsigned OFS_DEPTH   = 28;
  localparam int unsigned HDR_LAST    = 29;
  localparam int unsigned MIN_OFFSET  = 30;

  localparam logic [7:0]  SIG_B       = 8'h42;
  localparam logic [7:0]  SIG_M       = 8'h4d;
  localparam logic [15:0] DEPTH_16    = 16'd16;
  localparam logic [15:0] DEPTH_24    = 16'd24;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_BAD_SIG = 2'd2,
    KIND_BAD_HDR = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_SKIP = 6'b000100,
    PH_PIX  = 6'b001000,
    PH_PAD  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bsr_in_t;

  typedef struct packed {
    kind_e                  kind;
    logic [15:0]            pixel;
    logic [COORD_W-1:0]     column;
    logic [COORD_W-1:0]     row;
    logic [DIM_OUT_W-1:0]   image_width;
    logic [DIM_OUT_W-1:0]   image_height;
    logic [15:0]            bits_per_pixel;
    logic                   last_pixel;
  } bsr_out_t;

  function automatic logic [DIM_OUT_W-1:0] sat_dim(logic [31:0] v);
    logic [DIM_OUT_W-1:0] r;
    r = (v > 32'(DIM_SAT)) ? DIM_OUT_W'(DIM_SAT) : v[DIM_OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsr_if.sv @@
// ----------------------------------------------------------------------------
// bsr_if
// Valid/ready channels carrying input bytes and decoded result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsr_in_if;
  import bsr_pkg::*;

  logic    valid;
  logic    ready;
  bsr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsr_out_if;
  import bsr_pkg::*;

  logic     valid;
  logic     ready;
  bsr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bmp_stream_to_rgb565.sv @@
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565
// Decodes a bitmap file, one byte per word, into header and RGB565 pixel words.
// ----------------------------------------------------------------------------
// Bytes of the file arrive on in_i, one per word; start_of_file marks byte 0
// of a new file and restarts the parser. Decoded words leave on out_o: one
// status word (bad signature at byte 0 or 1, otherwise accepted or rejected
// header at byte 29) and then one pixel word per complete pixel with its
// column and flipped row. Bytes that complete nothing give no word. The
// block takes one byte every cycle while the result register can take the
// word it may make. An accepted byte is decoded from the input register and
// its word loaded into the result register. The input register and the result
// register sit either side of the decoder, so a byte is still taken while a
// word waits. When the receiver stalls, the pending word holds; bytes that
// make no word keep flowing, and input stalls only once a byte would need
// the occupied result register. After reset the parser waits for a
// signature, and the first byte counts as byte 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bmp_stream_to_rgb565 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bsr_in_if.sink    in_i,
  bsr_out_if.source out_o
);
  import bsr_pkg::*;

  logic     s1_valid;
  bsr_in_t  s1_item;
  logic     advance;
  logic     res_valid;
  bsr_out_t res;
  logic     out_free;

  assign advance = s1_valid && (!res_valid || out_free);

  bsr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  bsr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bsr_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  `ASSERT_AT(a_no_overwrite, (advance && res_valid) |-> out_free, "Result register overwritten while occupied.")
  `ASSERT_AT(a_ready_stall, !in_i.ready |-> s1_valid, "Input stalled with an empty input register.")

endmodule

`default_nettype wire

@@ rtl/core/bsr_in_stage.sv @@
// ----------------------------------------------------------------------------
// bsr_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsr_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bsr_in_if.sink               in_i,
  input  wire logic            advance_i,
  output      logic            valid_o,
  output      bsr_pkg::bsr_in_t item_o
);
  import bsr_pkg::*;

  logic    valid_q;
  logic    valid_d;
  bsr_in_t item_q;
  logic    take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/bsr_parser.sv @@
// ----------------------------------------------------------------------------
// bsr_parser
// Header parser and pixel converter; updates its state once per consumed byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bsr_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire bsr_pkg::bsr_in_t item_i,
  output      logic             res_valid_o,
  output      bsr_pkg::bsr_out_t res_o
);
  import bsr_pkg::*;

  phase_e              phase_q, phase_d, cur_phase;
  logic [31:0]         pos_q, pos_d, cur_pos;
  logic [31:0]         off_q, off_d;
  logic [31:0]         wid_q, wid_d;
  logic [31:0]         hgt_q, hgt_d;
  logic [15:0]         dep_q, dep_d;
  logic [15:0]         pb_q, pb_d;
  logic [1:0]          bip_q, bip_d;
  logic [COORD_W-1:0]  col_q, col_d;
  logic [COORD_W-1:0]  srow_q, srow_d;
  logic [1:0]          pad_q, pad_d;
  logic [COORD_W-1:0]  wm1_q, wm1_d;
  logic [COORD_W-1:0]  hm1_q, hm1_d;
  logic [1:0]          padamt_q, padamt_d;

  logic [7:0]          b;
  logic                take_px;
  logic                is24;
  logic                hdr_ok;
  logic [1:0]          lane;
  logic [1:0]          bytes_lo;

  assign b = item_i.data_byte;

  always_comb begin
    cur_phase = phase_q;
    cur_pos   = pos_q;
    off_d     = off_q;
    wid_d     = wid_q;
    hgt_d     = hgt_q;
    dep_d     = dep_q;
    pb_d      = pb_q;
    bip_d     = bip_q;
    col_d     = col_q;
    srow_d    = srow_q;
    pad_d     = pad_q;
    wm1_d     = wm1_q;
    hm1_d     = hm1_q;
    padamt_d  = padamt_q;
    take_px   = 1'b0;
    hdr_ok    = 1'b0;
    lane      = 2'd0;
    bytes_lo  = 2'd0;
    is24      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.start_of_file) begin
      cur_phase = PH_SIG;
      cur_pos   = '0;
      off_d     = '0;
      wid_d     = '0;
      hgt_d     = '0;
      dep_d     = '0;
      pb_d      = '0;
      bip_d     = '0;
      col_d     = '0;
      srow_d    = '0;
      pad_d     = '0;
    end

    phase_d = cur_phase;
    pos_d   = (&cur_pos) ? cur_pos : cur_pos + 32'd1;

    unique case (cur_phase)
      PH_SIG: begin
        if (b != ((cur_pos == '0) ? SIG_B : SIG_M)) begin
          phase_d     = PH_DONE;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_SIG;
        end else if (cur_pos != '0) begin
          phase_d = PH_HDR;
        end
      end
      PH_HDR: begin
        if (cur_pos >= 32'(OFS_OFFSET) && cur_pos <= 32'(OFS_OFFSET + 3)) begin
          lane = 2'(cur_pos - 32'(OFS_OFFSET));
          off_d[{lane, 3'b000} +: 8] = b;
        end else if (cur_pos >= 32'(OFS_WIDTH) && cur_pos <= 32'(OFS_WIDTH + 3)) begin
          lane = 2'(cur_pos - 32'(OFS_WIDTH));
          wid_d[{lane, 3'b000} +: 8] = b;
        end else if (cur_pos >= 32'(OFS_HEIGHT) && cur_pos <= 32'(OFS_HEIGHT + 3)) begin
          lane = 2'(cur_pos - 32'(OFS_HEIGHT));
          hgt_d[{lane, 3'b000} +: 8] = b;
        end else if (cur_pos >= 32'(OFS_DEPTH) && cur_pos <= 32'(OFS_DEPTH + 1)) begin
          lane = 2'(cur_pos - 32'(OFS_DEPTH));
          dep_d[{lane[0], 3'b000} +: 8] = b;
        end
        if (cur_pos >= 32'(HDR_LAST)) begin
          hdr_ok = (dep_d == DEPTH_16 || dep_d == DEPTH_24) &&
                   (wid_d != '0) && (wid_d <= 32'(MAX_DIM)) &&
                   (hgt_d != '0) && (hgt_d <= 32'(MAX_DIM)) &&
                   (off_d >= 32'(MIN_OFFSET));
          res_valid_o          = 1'b1;
          res_o.image_width    = sat_dim(wid_d);
          res_o.image_height   = sat_dim(hgt_d);
          res_o.bits_per_pixel = dep_d;
          if (hdr_ok) begin
            res_o.kind = KIND_HEADER;
            phase_d    = PH_SKIP;
            col_d      = '0;
            srow_d     = '0;
            bip_d      = '0;
            pb_d       = '0;
            pad_d      = '0;
            wm1_d      = COORD_W'(wid_d - 32'd1);
            hm1_d      = COORD_W'(hgt_d - 32'd1);
            bytes_lo   = (dep_d == DEPTH_24) ? 2'(wid_d[1:0] * 2'd3)
                                             : {wid_d[0], 1'b0};
            padamt_d   = 2'(2'd0 - bytes_lo);
          end else begin
            res_o.kind = KIND_BAD_HDR;
            phase_d    = PH_DONE;
          end
        end
      end
      PH_SKIP: begin
        if (cur_pos >= off_q) begin
          phase_d = PH_PIX;
          take_px = 1'b1;
        end
      end
      PH_PIX: begin
        take_px = 1'b1;
      end
      PH_PAD: begin
        pad_d = 2'(pad_q - 2'd1);
        if (pad_d == 2'd0) begin
          phase_d = PH_PIX;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (take_px) begin
      is24 = (dep_q == DEPTH_24);
      if (bip_q == 2'd0) begin
        pb_d  = {8'h00, b};
        bip_d = 2'd1;
      end else if (is24 && bip_q == 2'd1) begin
        pb_d[15:8] = b;
        bip_d      = 2'd2;
      end else begin
        bip_d        = 2'd0;
        pb_d         = '0;
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_PIXEL;
        res_o.pixel  = is24 ? {b[7:3], pb_q[15:10], pb_q[7:3]} : {b, pb_q[7:0]};
        res_o.column = col_q;
        res_o.row    = hm1_q - srow_q;
        if (col_q == wm1_q) begin
          if (srow_q == hm1_q) begin
            res_o.last_pixel = 1'b1;
            phase_d          = PH_DONE;
          end else begin
            col_d   = '0;
            srow_d  = srow_q + COORD_W'(1);
            pad_d   = padamt_q;
            phase_d = (padamt_q != 2'd0) ? PH_PAD : PH_PIX;
          end
        end else begin
          col_d = col_q + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      pos_q    <= '0;
      off_q    <= '0;
      wid_q    <= '0;
      hgt_q    <= '0;
      dep_q    <= '0;
      pb_q     <= '0;
      bip_q    <= '0;
      col_q    <= '0;
      srow_q   <= '0;
      pad_q    <= '0;
      wm1_q    <= '0;
      hm1_q    <= '0;
      padamt_q <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      off_q    <= off_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      dep_q    <= dep_d;
      pb_q     <= pb_d;
      bip_q    <= bip_d;
      col_q    <= col_d;
      srow_q   <= srow_d;
      pad_q    <= pad_d;
      wm1_q    <= wm1_d;
      hm1_q    <= hm1_d;
      padamt_q <= padamt_d;
    end
  end

  `ASSERT_AT(a_pixel_phase, (advance_i && res_valid_o && res_o.kind == KIND_PIXEL) |-> (!item_i.start_of_file && (phase_q == PH_SKIP || phase_q == PH_PIX)), "Pixel word produced outside the pixel data.")
  `ASSERT_AT(a_col_range, (phase_q == PH_PIX || phase_q == PH_PAD) |-> (col_q <= wm1_q), "Column count ran past the image width.")
  `ASSERT_AT(a_bip_16, (phase_q == PH_PIX && dep_q == DEPTH_16) |-> (bip_q != 2'd2), "A 16-bit pixel gathered a third byte.")
  `ASSERT_NEVER(a_bip_range, bip_q == 2'd3, "Byte-in-pixel count out of range.")

endmodule

`default_nettype wire

@@ rtl/core/bsr_out_stage.sv @@
// ----------------------------------------------------------------------------
// bsr_out_stage
// Result register: holds one decoded word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire bsr_pkg::bsr_out_t res_i,
  output      logic              free_o,
  bsr_out_if.source              out_o
);
  import bsr_pkg::*;

  logic     valid_q;
  logic     valid_d;
  bsr_out_t data_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

`default_nettype wire

@@ tb/bmp_stream_to_rgb565_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_test
// Self-checking testbench of the bitmap stream to RGB565 decoder.
// ----------------------------------------------------------------------------
// Bitmap files are built byte by byte and offered on the input channel. The
// files are mostly well formed, with random sizes, depths, offsets and pixel
// content. Others carry a broken signature, a rejected header, a missing
// restart mark or a truncated file. A scoreboard decodes every accepted byte
// on its own and compares each decoded word, field by field, with the
// oldest word it expects. Both sides idle at random. The receiver holds off
// once for a long stretch, and the sender twice waits for the block to
// drain. The last part of the run has no idling and carries the opening
// bytes of images of the largest width and the largest height.
// ----------------------------------------------------------------------------

module bmp_stream_to_rgb565_test;
  import bsr_pkg::*;

  class bmp_word_scoreboard;
    bsr_out_t    pending_words[$];
    int unsigned failures;
    int unsigned words_of_kind[4];
    phase_e      phase;
    logic [31:0] byte_pos;
    logic [31:0] data_offset;
    logic [31:0] width_word;
    logic [31:0] height_word;
    logic [31:0] column;
    logic [31:0] src_row;
    logic [15:0] depth_word;
    logic [15:0] pixel_acc;
    logic [1:0]  byte_in_px;
    logic [1:0]  pad_left;

    function new();
      restart();
    endfunction

    function void restart();
      phase       = PH_SIG;
      byte_pos    = '0;
      data_offset = '0;
      width_word  = '0;
      height_word = '0;
      column      = '0;
      src_row     = '0;
      depth_word  = '0;
      pixel_acc   = '0;
      byte_in_px  = '0;
      pad_left    = '0;
    endfunction

    function logic [12:0] clip13(logic [31:0] v);
      return (v > 32'd8191) ? 13'h1fff : v[12:0];
    endfunction

    function bit take_pixel_byte(logic [7:0] b, output bsr_out_t w);
      logic [15:0] px;
      logic [31:0] dest_row;
      logic [31:0] row_bytes;
      bit          last;
      w = '0;
      dest_row = height_word - 32'd1 - src_row;
      last = 1'b0;
      if (depth_word == DEPTH_16) begin
        if (byte_in_px == 2'd0) begin
          pixel_acc  = {8'h00, b};
          byte_in_px = 2'd1;
          return 1'b0;
        end
        px = {b, pixel_acc[7:0]};
      end else begin
        if (byte_in_px == 2'd0) begin
          pixel_acc  = {8'h00, b};
          byte_in_px = 2'd1;
          return 1'b0;
        end
        if (byte_in_px == 2'd1) begin
          pixel_acc[15:8] = b;
          byte_in_px      = 2'd2;
          return 1'b0;
        end
        px = {b[7:3], pixel_acc[15:10], pixel_acc[7:3]};
      end
      byte_in_px = 2'd0;
      pixel_acc  = '0;
      w.kind   = KIND_PIXEL;
      w.pixel  = px;
      w.column = column[COORD_W-1:0];
      w.row    = dest_row[COORD_W-1:0];
      if (column == width_word - 32'd1) begin
        if (src_row == height_word - 32'd1) begin
          last  = 1'b1;
          phase = PH_DONE;
        end else begin
          column    = '0;
          src_row   = src_row + 32'd1;
          row_bytes = width_word * ((depth_word == DEPTH_24) ? 32'd3 : 32'd2);
          pad_left  = 2'd0 - row_bytes[1:0];
          phase     = (pad_left != 2'd0) ? PH_PAD : PH_PIX;
        end
      end else begin
        column = column + 32'd1;
      end
      w.last_pixel = last;
      return 1'b1;
    endfunction

    function bit decode_byte(bsr_in_t in_word, output bsr_out_t w);
      logic [7:0]  b;
      logic [31:0] pos;
      b = in_word.data_byte;
      w = '0;
      if (in_word.start_of_file) restart();
      pos = byte_pos;
      if (byte_pos != 32'hffff_ffff) byte_pos = byte_pos + 32'd1;
      case (phase)
        PH_SIG: begin
          if (b != ((pos == 0) ? SIG_B : SIG_M)) begin
            phase  = PH_DONE;
            w.kind = KIND_BAD_SIG;
            return 1'b1;
          end
          if (pos != 0) phase = PH_HDR;
          return 1'b0;
        end
        PH_HDR: begin
          if (pos >= OFS_OFFSET && pos < OFS_OFFSET + 4)
            data_offset |= 32'(b) << (8 * (pos - OFS_OFFSET));
          else if (pos >= OFS_WIDTH && pos < OFS_WIDTH + 4)
            width_word |= 32'(b) << (8 * (pos - OFS_WIDTH));
          else if (pos >= OFS_HEIGHT && pos < OFS_HEIGHT + 4)
            height_word |= 32'(b) << (8 * (pos - OFS_HEIGHT));
          else if (pos >= OFS_DEPTH && pos <= HDR_LAST)
            depth_word |= 16'(b) << (8 * (pos - OFS_DEPTH));
          if (pos < HDR_LAST) return 1'b0;
          w.image_width    = clip13(width_word);
          w.image_height   = clip13(height_word);
          w.bits_per_pixel = depth_word;
          if ((depth_word != DEPTH_16 && depth_word != DEPTH_24) ||
              width_word < 1 || width_word > MAX_DIM ||
              height_word < 1 || height_word > MAX_DIM ||
              data_offset < MIN_OFFSET) begin
            phase  = PH_DONE;
            w.kind = KIND_BAD_HDR;
            return 1'b1;
          end
          phase      = PH_SKIP;
          column     = '0;
          src_row    = '0;
          byte_in_px = '0;
          pixel_acc  = '0;
          pad_left   = '0;
          w.kind     = KIND_HEADER;
          return 1'b1;
        end
        PH_SKIP: begin
          if (pos < data_offset) return 1'b0;
          phase = PH_PIX;
          return take_pixel_byte(b, w);
        end
        PH_PIX: begin
          return take_pixel_byte(b, w);
        end
        PH_PAD: begin
          pad_left = pad_left - 2'd1;
          if (pad_left == 2'd0) phase = PH_PIX;
          return 1'b0;
        end
        default: begin
          return 1'b0;
        end
      endcase
    endfunction

    function void take_byte(bsr_in_t in_word);
      bsr_out_t want;
      if (decode_byte(in_word, want)) pending_words.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_word(bsr_out_t got);
      bsr_out_t want;
      if (pending_words.size() == 0) begin
        $error("word with kind %0d arrived while none was expected", got.kind);
        failures++;
        return;
      end
      want = pending_words.pop_front();
      words_of_kind[want.kind]++;
      compare("kind", want.kind, got.kind);
      compare("pixel", want.pixel, got.pixel);
      compare("column", want.column, got.column);
      compare("row", want.row, got.row);
      compare("image_width", want.image_width, got.image_width);
      compare("image_height", want.image_height, got.image_height);
      compare("bits_per_pixel", want.bits_per_pixel, got.bits_per_pixel);
      compare("last_pixel", want.last_pixel, got.last_pixel);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bsr_in_if  in_ch ();
  bsr_out_if out_ch ();

  bmp_stream_to_rgb565 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bmp_word_scoreboard scoreboard = new();

  logic [7:0]  file_bytes[$];
  bit          quiet;
  bit          long_hold_req;
  int unsigned files_sent;
  int unsigned bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("bmp_stream_to_rgb565 test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) scoreboard.take_byte(in_ch.data);
      if (out_ch.valid && out_ch.ready) scoreboard.check_word(out_ch.data);
    end
  end

  // The long hold lets the block fill up while the sender keeps offering bytes.
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 200;
      end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 7);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void make_bmp(input logic [31:0] offset, input logic [31:0] wid,
                                   input logic [31:0] hgt, input logic [15:0] bpp);
    logic [7:0]  b;
    int unsigned row_bytes;
    int unsigned pad;
    file_bytes.delete();
    for (int i = 0; i < 30; i++) begin
      b = 8'($urandom);
      if (i == 0) b = SIG_B;
      else if (i == 1) b = SIG_M;
      else if (i >= 10 && i <= 13) b = offset[8 * (i - 10) +: 8];
      else if (i >= 18 && i <= 21) b = wid[8 * (i - 18) +: 8];
      else if (i >= 22 && i <= 25) b = hgt[8 * (i - 22) +: 8];
      else if (i >= 28) b = bpp[8 * (i - 28) +: 8];
      file_bytes.push_back(b);
    end
    while (file_bytes.size() < offset && file_bytes.size() < 200)
      file_bytes.push_back(8'($urandom));
    if ((bpp == DEPTH_16 || bpp == DEPTH_24) && offset >= 30 && offset < 200 &&
        wid >= 1 && wid <= MAX_DIM && hgt >= 1 && hgt <= MAX_DIM) begin
      row_bytes = wid * ((bpp == DEPTH_24) ? 3 : 2);
      pad = (4 - row_bytes % 4) % 4;
      for (int r = 0; r < hgt; r++) begin
        for (int k = 0; k < row_bytes + pad; k++) file_bytes.push_back(8'($urandom));
      end
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] bad_dim();
    case ($urandom_range(0, 2))
      0:       return 32'd0;
      1:       return MAX_DIM + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.data  <= '{data_byte: b, start_of_file: sof};
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_file(input bit mark, input int count);
    for (int i = 0; i < count; i++) send_byte(file_bytes[i], mark && i == 0);
    files_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_file();
    logic [31:0] offset;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [15:0] bpp;
    int unsigned pick;
    int          count;
    bit          mark;
    pick   = $urandom_range(0, 99);
    bpp    = $urandom_range(0, 1) ? DEPTH_24 : DEPTH_16;
    wid    = $urandom_range(1, 6);
    hgt    = $urandom_range(1, 4);
    offset = $urandom_range(30, 40);
    mark   = 1'b1;
    if (pick < 6) bpp = 16'($urandom);
    else if (pick < 9) wid = bad_dim();
    else if (pick < 12) hgt = bad_dim();
    else if (pick < 15) offset = $urandom_range(0, 29);
    else if (pick < 16) offset = 32'h0100_0020;
    make_bmp(offset, wid, hgt, bpp);
    count = file_bytes.size();
    if (pick >= 20 && pick < 25)
      file_bytes[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    else if (pick >= 25 && pick < 31)
      count = $urandom_range(1, count - 1);
    else if (pick >= 31 && pick < 34)
      mark = 1'b0;
    send_file(mark, count);
  endtask

  initial begin
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    files_sent    = 0;
    bytes_sent    = 0;
    rst_ni        = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first file after reset carries no restart mark.
    make_bmp(30, 2, 2, DEPTH_16);
    send_file(1'b0, file_bytes.size());
    make_bmp(30, 3, 2, DEPTH_24);
    for (int i = 30; i < file_bytes.size(); i++) file_bytes[i] = (i % 2) ? 8'hff : 8'h00;
    send_file(1'b1, file_bytes.size());
    make_bmp(31, 3, 2, DEPTH_16);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 1, 3, DEPTH_24);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 1, 1, DEPTH_16);
    file_bytes[0] = 8'h00;
    send_file(1'b1, 4);
    make_bmp(30, 1, 1, DEPTH_16);
    file_bytes[1] = 8'hff;
    send_file(1'b1, 4);
    make_bmp(30, 2, 2, 16'd8);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 0, 2, DEPTH_24);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 2, MAX_DIM + 1, DEPTH_16);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 32'h0001_2345, 2, DEPTH_16);
    send_file(1'b1, file_bytes.size());
    make_bmp(29, 2, 2, DEPTH_24);
    send_file(1'b1, file_bytes.size());
    make_bmp(30, 4, 4, DEPTH_24);
    send_file(1'b1, 40);
    pause_until_drained();

    while (bytes_sent < 700) begin
      if (files_sent == 14) begin
        long_hold_req = 1'b1;
        make_bmp(30, 6, 4, DEPTH_16);
        send_file(1'b1, file_bytes.size());
        pause_until_drained();
      end
      random_file();
    end

    quiet = 1'b1;
    make_bmp(30, MAX_DIM, 1, DEPTH_16);
    send_file(1'b1, 128);
    make_bmp(54, 1, MAX_DIM, DEPTH_24);
    send_file(1'b1, 150);
    repeat (5) random_file();
    in_ch.valid <= 1'b0;

    while (scoreboard.pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (scoreboard.pending_words.size() != 0) begin
      $error("%0d expected words never arrived", scoreboard.pending_words.size());
      scoreboard.failures++;
    end
    $display("Sent %0d files in %0d bytes.", files_sent, bytes_sent);
    $display("Checked %0d pixel, %0d header, %0d bad signature and %0d rejected header words.",
             scoreboard.words_of_kind[KIND_PIXEL], scoreboard.words_of_kind[KIND_HEADER],
             scoreboard.words_of_kind[KIND_BAD_SIG], scoreboard.words_of_kind[KIND_BAD_HDR]);
    if (scoreboard.failures == 0) begin
      $display("bmp_stream_to_rgb565 test passed");
    end else begin
      $display("bmp_stream_to_rgb565 test failed");
    end
    $finish;
  end

endmodule

@@ bmp_stream_to_rgb565.f @@
+incdir+rtl/core
rtl/core/bsr_pkg.sv
rtl/core/bsr_if.sv
rtl/core/bsr_in_stage.sv
rtl/core/bsr_parser.sv
rtl/core/bsr_out_stage.sv
rtl/core/bmp_stream_to_rgb565.sv
tb/bmp_stream_to_rgb565_test.sv
